>>> rtl/core/sida_pkg.sv
// Shared constants for the signed integer to decimal ASCII converter.
// No dependencies; used by the top level and its port checker.
package sida_pkg;

  // Input word width and decimal digit storage (10 BCD digits cover 2^32 - 1)
  localparam int unsigned ValueW    = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned BcdW      = 4 * NumDigits;

  // ASCII codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharMinus = 8'h2D;

endpackage

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
// Depends on sida_pkg (widths and ASCII codes).
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+----------------------------------
//  input    | value_i                       | taken when start && !busy
//  result   | character_o, last_o           | strobe_o high for one cycle each
//
// A word is loaded, then goes through bit-serial shift-and-add-3 binary to BCD
// conversion, then a minus sign is emitted when negative, then the 10 BCD digits
// are scanned from the top BCD digit down (leading zeros give no strobe);
// busy is high from the load until the last character.
// Reset (rst_ni low, asynchronous) returns to idle with no strobe pending.
// The receiver cannot stall; each character is shown for exactly one cycle.
module signed_int_to_decimal_ascii (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sida_pkg::ValueW-1:0] value_i,
  output logic                               strobe_o,
  output logic [7:0]                         character_o,
  output logic                               last_o
);
  import sida_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSign,
    StEmit
  } state_e;

  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits);

  state_e               state_q;
  logic [ValueW-1:0]    mag_q;
  logic [BcdW-1:0]      bcd_q;
  logic [BcdW-1:0]      bcd_adj;
  logic [BitCntW-1:0]   bit_cnt_q;
  logic [DigCntW-1:0]   dig_cnt_q;
  logic                 neg_q;
  logic                 lead_q;
  logic [ValueW-1:0]    raw;
  logic [ValueW-1:0]    mag_d;
  logic [3:0]           top_dig;
  logic                 show_dig;

  // Magnitude of the input, taken unsigned so the most negative value works
  assign raw   = value_i;
  assign mag_d = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;

  // Add 3 to every BCD digit that is 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Digit scan: skip leading zeros, always show the units digit
  assign top_dig  = bcd_q[BcdW-1 -: 4];
  assign show_dig = lead_q || (top_dig != 4'd0) || (dig_cnt_q == '0);

  assign busy = (state_q != StIdle);

  // Sequencer with registered result outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      strobe_o    <= 1'b0;
      last_o      <= 1'b0;
      character_o <= '0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      neg_q       <= 1'b0;
      lead_q      <= 1'b0;
      mag_q       <= '0;
      bcd_q       <= '0;
    end else begin
      strobe_o <= 1'b0;
      last_o   <= 1'b0;
      case (state_q)
        StIdle: begin
          if (start) begin
            mag_q     <= mag_d;
            neg_q     <= value_i[ValueW-1];
            bcd_q     <= '0;
            bit_cnt_q <= BitCntW'(ValueW - 1);
            state_q   <= StConv;
          end
        end
        StConv: begin
          // One input bit per cycle into the BCD register
          bcd_q <= {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
          mag_q <= {mag_q[ValueW-2:0], 1'b0};
          if (bit_cnt_q == '0) begin
            dig_cnt_q <= DigCntW'(NumDigits - 1);
            lead_q    <= 1'b0;
            state_q   <= neg_q ? StSign : StEmit;
          end else begin
            bit_cnt_q <= bit_cnt_q - 1'b1;
          end
        end
        StSign: begin
          strobe_o    <= 1'b1;
          character_o <= CharMinus;
          state_q     <= StEmit;
        end
        StEmit: begin
          // One BCD digit per cycle, most significant first
          if (show_dig) begin
            strobe_o    <= 1'b1;
            character_o <= CharZero | {4'd0, top_dig};
            lead_q      <= 1'b1;
          end
          bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
          if (dig_cnt_q == '0) begin
            last_o  <= 1'b1;
            state_q <= StIdle;
          end else begin
            dig_cnt_q <= dig_cnt_q - 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/sida_checker.sv
// Port-level checks for signed_int_to_decimal_ascii, attached by bind.
// Depends on sida_pkg (ASCII codes).
module sida_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       strobe_o,
  input logic [7:0] character_o,
  input logic       last_o
);
  import sida_pkg::*;

  // A taken word keeps the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after a word was taken");

  // Only a sign or a digit is emitted
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (character_o == CharMinus) ||
                 ((character_o >= CharZero) && (character_o <= CharNine)))
    else $error("illegal character emitted");

  // The sign is never the final character
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (character_o == CharMinus) |-> !last_o)
    else $error("minus sign flagged as last");

  // Once digits start, they run without gaps to the last one
  a_digits_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o && (character_o != CharMinus) |=> strobe_o)
    else $error("gap inside the digit run");

  // Nothing follows the last character in the next cycle
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("strobe right after the last character");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .strobe_o    (strobe_o),
  .character_o (character_o),
  .last_o      (last_o)
);
